// ----- design/rtfe_pkg.sv -----
`default_nettype none
package rtfe_pkg;

  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int QUOT_W    = 32;
  // dividend and shifted divisor fit here for any fraction width up to 32
  localparam int REM_W     = PROD_W + QUOT_W;
  localparam int NUM_COEFS = 4;
  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_NUM_S3,
    REG_NUM_S2,
    REG_NUM_S1,
    REG_NUM_S0,
    REG_DEN_S3,
    REG_DEN_S2,
    REG_DEN_S1,
    REG_DEN_S0
  } reg_idx_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_DEN_ZERO = 2'd1;
  localparam logic [1:0] STATUS_SAT      = 2'd2;

  // control that rides along with each word
  typedef struct packed {
    logic valid;
    logic sat;
    logic zero;
  } rtfe_ctl_t;

endpackage
`default_nettype wire

// ----- design/rtfe_horner.sv -----
`default_nettype none
// One Horner step acc = acc * s + c for numerator and denominator, two stages.
module rtfe_horner import rtfe_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire rtfe_ctl_t                ctl_in,
  input  wire logic signed [DATA_W-1:0] s_re_in,
  input  wire logic signed [DATA_W-1:0] s_im_in,
  input  wire logic signed [DATA_W-1:0] num_re_in,
  input  wire logic signed [DATA_W-1:0] num_im_in,
  input  wire logic signed [DATA_W-1:0] den_re_in,
  input  wire logic signed [DATA_W-1:0] den_im_in,
  input  wire logic signed [DATA_W-1:0] num_coef,
  input  wire logic signed [DATA_W-1:0] den_coef,
  output rtfe_ctl_t                     ctl_out,
  output logic signed [DATA_W-1:0]      s_re_out,
  output logic signed [DATA_W-1:0]      s_im_out,
  output logic signed [DATA_W-1:0]      num_re_out,
  output logic signed [DATA_W-1:0]      num_im_out,
  output logic signed [DATA_W-1:0]      den_re_out,
  output logic signed [DATA_W-1:0]      den_im_out
);

  localparam int SUM_W = PROD_W + 2;

  function automatic logic ovf32(input logic signed [SUM_W-1:0] v);
    return !((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1]));
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    r = v[DATA_W-1:0];
    if (ovf32(v)) r = v[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    return r;
  endfunction

  rtfe_ctl_t                ctl_a;
  logic signed [DATA_W-1:0] s_re_a, s_im_a, nc_a, dc_a;
  logic signed [PROD_W-1:0] n_rr, n_ii, n_ri, n_ir, d_rr, d_ii, d_ri, d_ir;

  logic signed [PROD_W:0]  n_re_p, n_im_p, d_re_p, d_im_p;
  logic signed [SUM_W-1:0] n_re_s, n_im_s, d_re_s, d_im_s;
  logic                    sat_next;

  always_comb begin
    n_re_p = n_rr - n_ii;
    n_im_p = n_ri + n_ir;
    d_re_p = d_rr - d_ii;
    d_im_p = d_ri + d_ir;
    // arithmetic shift floors, as required
    n_re_s = SUM_W'(n_re_p >>> FRAC_BITS) + SUM_W'(nc_a);
    n_im_s = SUM_W'(n_im_p >>> FRAC_BITS);
    d_re_s = SUM_W'(d_re_p >>> FRAC_BITS) + SUM_W'(dc_a);
    d_im_s = SUM_W'(d_im_p >>> FRAC_BITS);
    sat_next = ctl_a.sat | ovf32(n_re_s) | ovf32(n_im_s) | ovf32(d_re_s) | ovf32(d_im_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a   <= '0;
      ctl_out <= '0;
    end else if (en) begin
      ctl_a   <= ctl_in;
      ctl_out <= '{valid: ctl_a.valid, sat: sat_next, zero: ctl_a.zero};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_re_a     <= s_re_in;
      s_im_a     <= s_im_in;
      nc_a       <= num_coef;
      dc_a       <= den_coef;
      n_rr       <= num_re_in * s_re_in;
      n_ii       <= num_im_in * s_im_in;
      n_ri       <= num_re_in * s_im_in;
      n_ir       <= num_im_in * s_re_in;
      d_rr       <= den_re_in * s_re_in;
      d_ii       <= den_im_in * s_im_in;
      d_ri       <= den_re_in * s_im_in;
      d_ir       <= den_im_in * s_re_in;
      s_re_out   <= s_re_a;
      s_im_out   <= s_im_a;
      num_re_out <= sat32(n_re_s);
      num_im_out <= sat32(n_im_s);
      den_re_out <= sat32(d_re_s);
      den_im_out <= sat32(d_im_s);
    end
  end

endmodule
`default_nettype wire

// ----- design/rtfe_qprep.sv -----
`default_nettype none
// Quotient setup: cross products, |D|^2, sign and magnitude. Two stages.
module rtfe_qprep import rtfe_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire rtfe_ctl_t                ctl_in,
  input  wire logic signed [DATA_W-1:0] nr,
  input  wire logic signed [DATA_W-1:0] ni,
  input  wire logic signed [DATA_W-1:0] dr,
  input  wire logic signed [DATA_W-1:0] di,
  output rtfe_ctl_t                     ctl_out,
  output logic                          neg_re,
  output logic [PROD_W-1:0]             mag_re,
  output logic                          neg_im,
  output logic [PROD_W-1:0]             mag_im,
  output logic [PROD_W-1:0]             den
);

  rtfe_ctl_t                ctl1;
  logic signed [PROD_W-1:0] p_nrdr, p_nidi, p_nidr, p_nrdi, p_drdr, p_didi;
  logic signed [PROD_W:0]   re_sum, im_sum, re_abs, im_abs;
  logic [PROD_W-1:0]        den_sum;

  always_comb begin
    re_sum  = p_nrdr + p_nidi;
    im_sum  = p_nidr - p_nrdi;
    re_abs  = re_sum[PROD_W] ? -re_sum : re_sum;
    im_abs  = im_sum[PROD_W] ? -im_sum : im_sum;
    // both squares are non-negative and at most 2^62, so the sum fits
    den_sum = $unsigned(p_drdr) + $unsigned(p_didi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1    <= '0;
      ctl_out <= '0;
    end else if (en) begin
      ctl1    <= ctl_in;
      ctl_out <= '{valid: ctl1.valid, sat: ctl1.sat, zero: (den_sum == '0)};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_nrdr <= nr * dr;
      p_nidi <= ni * di;
      p_nidr <= ni * dr;
      p_nrdi <= nr * di;
      p_drdr <= dr * dr;
      p_didi <= di * di;
      neg_re <= re_sum[PROD_W];
      mag_re <= re_abs[PROD_W-1:0];
      neg_im <= im_sum[PROD_W];
      mag_im <= im_abs[PROD_W-1:0];
      den    <= den_sum;
    end
  end

endmodule
`default_nettype wire

// ----- design/rtfe_div_lane.sv -----
`default_nettype none
// Pipelined restoring divider: (mag << FRAC_BITS) / den, one quotient bit per
// stage, saturated to 32 bit signed. QUOT_W + 2 stages.
module rtfe_div_lane import rtfe_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire rtfe_ctl_t         ctl_in,
  input  wire logic              neg_in,
  input  wire logic [PROD_W-1:0] mag_in,
  input  wire logic [PROD_W-1:0] den_in,
  output rtfe_ctl_t              ctl_out,
  output logic [DATA_W-1:0]      value
);

  rtfe_ctl_t         ctl_d [QUOT_W+1];
  logic              neg_d [QUOT_W+1];
  logic              ovf_d [QUOT_W+1];
  logic [PROD_W-1:0] den_d [QUOT_W+1];
  logic [REM_W-1:0]  rem_d [QUOT_W+1];
  logic [QUOT_W-1:0] q_d   [QUOT_W+1];

  logic [REM_W-1:0] x0;

  assign x0 = REM_W'(mag_in) << FRAC_BITS;

  // quotient of 2^32 or more always saturates
  always_ff @(posedge clk) begin
    if (rst) ctl_d[0] <= '0;
    else if (en) ctl_d[0] <= ctl_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_d[0] <= neg_in;
      den_d[0] <= den_in;
      rem_d[0] <= x0;
      q_d[0]   <= '0;
      ovf_d[0] <= (x0 >= (REM_W'(den_in) << QUOT_W));
    end
  end

  for (genvar i = 0; i < QUOT_W; i++) begin : g_stage
    logic [REM_W-1:0] trial;
    logic             take;

    assign trial = REM_W'(den_d[i]) << (QUOT_W - 1 - i);
    assign take  = (rem_d[i] >= trial);

    always_ff @(posedge clk) begin
      if (rst) ctl_d[i+1] <= '0;
      else if (en) ctl_d[i+1] <= ctl_d[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg_d[i+1] <= neg_d[i];
        ovf_d[i+1] <= ovf_d[i];
        den_d[i+1] <= den_d[i];
        rem_d[i+1] <= take ? rem_d[i] - trial : rem_d[i];
        q_d[i+1]   <= {q_d[i][QUOT_W-2:0], take};
      end
    end
  end

  logic [QUOT_W-1:0] lim, q_sat;
  logic              over;
  logic [DATA_W-1:0] v_next;

  always_comb begin
    lim    = neg_d[QUOT_W] ? {1'b1, {(QUOT_W-1){1'b0}}} : {1'b0, {(QUOT_W-1){1'b1}}};
    over   = ovf_d[QUOT_W] || (q_d[QUOT_W] > lim);
    q_sat  = over ? lim : q_d[QUOT_W];
    v_next = neg_d[QUOT_W] ? DATA_W'(-q_sat) : DATA_W'(q_sat);
    if (ctl_d[QUOT_W].zero) v_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) ctl_out <= '0;
    else if (en) ctl_out <= '{valid: ctl_d[QUOT_W].valid, sat: ctl_d[QUOT_W].sat | over,
                              zero: ctl_d[QUOT_W].zero};
  end

  always_ff @(posedge clk) begin
    if (en) value <= v_next;
  end

endmodule
`default_nettype wire

// ----- design/rational_transfer_function_eval.sv -----
// Rational transfer function evaluator, H(s) = N(s) / D(s), signed fixed point.
// Input stream s_*: tdata carries the complex point s (s_real low, s_imag high).
// Output stream m_*: tdata carries h_real / h_imag, tuser the status
// (0 ok, 1 denominator value zero with a zero result, 2 saturated).
// Coefficients are written on cfg_we / cfg_addr / cfg_wdata while idle;
// index 0..3 numerator s^3..s^0, 4..7 denominator s^3..s^0.
// Throughput: one word per cycle unless the output stalls; fully pipelined.
// Pipeline: two stages per Horner step (multiply, then shift/add/saturate),
// two for the quotient setup, 34 in the bit-per-stage divider (range check,
// 32 quotient bits, saturation) and the output register.
// Stall: the whole pipeline moves on one enable; while a result sits in the
// output register unaccepted, s_tready drops and nothing is lost or repeated.
// Reset: synchronous; clears all valid bits, coefficients go to N = D = 1.0.
`default_nettype none
module rational_transfer_function_eval import rtfe_pkg::*; #(
  parameter int TERMS     = 4,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [2*DATA_W-1:0]    s_tdata,   // s_real, s_imag
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [2*DATA_W-1:0]         m_tdata,   // h_real, h_imag
  output logic [1:0]                  m_tuser,   // status
  input  wire logic                   cfg_we,
  input  wire logic [REG_IDX_W-1:0]   cfg_addr,
  input  wire logic [DATA_W-1:0]      cfg_wdata
);

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // coefficient registers, indexed by power of s
  logic signed [DATA_W-1:0] num_c [NUM_COEFS];
  logic signed [DATA_W-1:0] den_c [NUM_COEFS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_COEFS; k++) begin
        num_c[k] <= '0;
        den_c[k] <= '0;
      end
      num_c[0] <= DATA_W'(1) << FRAC_BITS;
      den_c[0] <= DATA_W'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_NUM_S3: num_c[3] <= cfg_wdata;
        REG_NUM_S2: num_c[2] <= cfg_wdata;
        REG_NUM_S1: num_c[1] <= cfg_wdata;
        REG_NUM_S0: num_c[0] <= cfg_wdata;
        REG_DEN_S3: den_c[3] <= cfg_wdata;
        REG_DEN_S2: den_c[2] <= cfg_wdata;
        REG_DEN_S1: den_c[1] <= cfg_wdata;
        REG_DEN_S0: den_c[0] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Horner chain, highest power first; step 0 starts from a zero accumulator
  rtfe_ctl_t                h_ctl  [TERMS+1];
  logic signed [DATA_W-1:0] h_sre  [TERMS+1];
  logic signed [DATA_W-1:0] h_sim  [TERMS+1];
  logic signed [DATA_W-1:0] h_nre  [TERMS+1];
  logic signed [DATA_W-1:0] h_nim  [TERMS+1];
  logic signed [DATA_W-1:0] h_dre  [TERMS+1];
  logic signed [DATA_W-1:0] h_dim  [TERMS+1];

  assign h_ctl[0] = '{valid: s_tvalid, sat: 1'b0, zero: 1'b0};
  assign h_sre[0] = s_tdata[DATA_W-1:0];
  assign h_sim[0] = s_tdata[2*DATA_W-1:DATA_W];
  assign h_nre[0] = '0;
  assign h_nim[0] = '0;
  assign h_dre[0] = '0;
  assign h_dim[0] = '0;

  for (genvar t = 0; t < TERMS; t++) begin : g_horner
    rtfe_horner #(.FRAC_BITS(FRAC_BITS)) u_step (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .ctl_in     (h_ctl[t]),
      .s_re_in    (h_sre[t]),
      .s_im_in    (h_sim[t]),
      .num_re_in  (h_nre[t]),
      .num_im_in  (h_nim[t]),
      .den_re_in  (h_dre[t]),
      .den_im_in  (h_dim[t]),
      .num_coef   (num_c[TERMS-1-t]),
      .den_coef   (den_c[TERMS-1-t]),
      .ctl_out    (h_ctl[t+1]),
      .s_re_out   (h_sre[t+1]),
      .s_im_out   (h_sim[t+1]),
      .num_re_out (h_nre[t+1]),
      .num_im_out (h_nim[t+1]),
      .den_re_out (h_dre[t+1]),
      .den_im_out (h_dim[t+1])
    );
  end

  // s is not needed past the last step
  logic unused_s;
  assign unused_s = ^{h_sre[TERMS], h_sim[TERMS]};

  rtfe_ctl_t         q_ctl;
  logic              q_neg_re, q_neg_im;
  logic [PROD_W-1:0] q_mag_re, q_mag_im, q_den;

  rtfe_qprep u_qprep (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (h_ctl[TERMS]),
    .nr      (h_nre[TERMS]),
    .ni      (h_nim[TERMS]),
    .dr      (h_dre[TERMS]),
    .di      (h_dim[TERMS]),
    .ctl_out (q_ctl),
    .neg_re  (q_neg_re),
    .mag_re  (q_mag_re),
    .neg_im  (q_neg_im),
    .mag_im  (q_mag_im),
    .den     (q_den)
  );

  rtfe_ctl_t         re_ctl, im_ctl;
  logic [DATA_W-1:0] re_val, im_val;

  rtfe_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_re (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (q_ctl),
    .neg_in  (q_neg_re),
    .mag_in  (q_mag_re),
    .den_in  (q_den),
    .ctl_out (re_ctl),
    .value   (re_val)
  );

  rtfe_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_im (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (q_ctl),
    .neg_in  (q_neg_im),
    .mag_in  (q_mag_im),
    .den_in  (q_den),
    .ctl_out (im_ctl),
    .value   (im_val)
  );

  logic [1:0] status_next;
  logic       unused_im;

  // zero denominator wins over saturation
  always_comb begin
    if (re_ctl.zero) status_next = STATUS_DEN_ZERO;
    else if (re_ctl.sat || im_ctl.sat) status_next = STATUS_SAT;
    else status_next = STATUS_OK;
  end
  assign unused_im = im_ctl.valid ^ im_ctl.zero;

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= re_ctl.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {im_val, re_val};
      m_tuser <= status_next;
    end
  end

`ifndef ASSERT_OFF
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == STATUS_OK || m_tuser == STATUS_DEN_ZERO ||
                  m_tuser == STATUS_SAT))
    else $error("status code out of range");

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == STATUS_DEN_ZERO) |-> (m_tdata == '0))
    else $error("zero denominator gave a nonzero result");

  // zero flag only means something on a valid word
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (re_ctl.valid == im_ctl.valid) && (!re_ctl.valid || (re_ctl.zero == im_ctl.zero)))
    else $error("divider lanes out of step");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");
`endif

endmodule
`default_nettype wire

// ----- dv/rational_transfer_function_eval_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module rational_transfer_function_eval_tb;
  import rtfe_pkg::*;

  localparam int FRAC = 16;
  localparam int DRAIN_CYCLES = 60;  // longer than the pipeline

  typedef logic signed [127:0] wide_t;

  // expected output word
  typedef struct {
    logic signed [31:0] h_re;
    logic signed [31:0] h_im;
    logic [1:0]         status;
  } h_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;  // s_real, s_imag
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;       // h_real, h_imag
  logic [1:0] m_tuser;        // status
  logic cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_addr = '0;
  logic [DATA_W-1:0] cfg_wdata = '0;

  rational_transfer_function_eval u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // local copy of the coefficients, indexed by power of s
  logic signed [31:0] num_k [4];
  logic signed [31:0] den_k [4];

  h_word_t h_expected [$];
  int errors = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;

  function automatic wide_t clamp32(wide_t v, inout bit sat);
    if (v > wide_t'(32'sh7fffffff)) begin
      sat = 1'b1;
      return wide_t'(32'sh7fffffff);
    end
    if (v < -wide_t'(64'sh80000000)) begin
      sat = 1'b1;
      return -wide_t'(64'sh80000000);
    end
    return v;
  endfunction

  // complex Horner, highest power first; each part floor-shifted and clamped
  function automatic void horner_eval(input logic signed [31:0] k [4], input wide_t sr,
                                      input wide_t si, output wide_t ar, output wide_t ai,
                                      inout bit sat);
    wide_t pr, pi;
    ar = 0;
    ai = 0;
    for (int p = 3; p >= 0; p--) begin
      pr = ar * sr - ai * si;
      pi = ar * si + ai * sr;
      ar = clamp32((pr >>> FRAC) + wide_t'(k[p]), sat);
      ai = clamp32(pi >>> FRAC, sat);
    end
  endfunction

  function automatic h_word_t eval_h(logic signed [31:0] s_re, logic signed [31:0] s_im);
    h_word_t r;
    wide_t sr, si, nr, ni, dr, di, den, qr, qi;
    bit sat;
    sat = 1'b0;
    sr = wide_t'(s_re);
    si = wide_t'(s_im);
    horner_eval(num_k, sr, si, nr, ni, sat);
    horner_eval(den_k, sr, si, dr, di, sat);
    if (dr == 0 && di == 0) begin
      r.h_re = '0;
      r.h_im = '0;
      r.status = STATUS_DEN_ZERO;
      return r;
    end
    den = dr * dr + di * di;
    // signed division truncates toward zero
    qr = clamp32(((nr * dr + ni * di) <<< FRAC) / den, sat);
    qi = clamp32(((ni * dr - nr * di) <<< FRAC) / den, sat);
    r.h_re = qr[31:0];
    r.h_im = qi[31:0];
    r.status = sat ? STATUS_SAT : STATUS_OK;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %h want %h", $realtime, field, got, want);
    errors++;
  endtask

  // receiver: random back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // compare each output word with the oldest expectation
  always @(posedge clk) begin
    h_word_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (h_expected.size() == 0) begin
        report_mismatch("unexpected word", m_tdata[31:0], '0);
      end else begin
        w = h_expected.pop_front();
        if (m_tdata[31:0] !== w.h_re) report_mismatch("h_real", m_tdata[31:0], w.h_re);
        if (m_tdata[63:32] !== w.h_im) report_mismatch("h_imag", m_tdata[63:32], w.h_im);
        if (m_tuser !== w.status) report_mismatch("status", 32'(m_tuser), 32'(w.status));
      end
    end
  end

  // one point into the block; tvalid stays high between back-to-back words
  task automatic send_point(logic [31:0] s_re, logic [31:0] s_im);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {s_im, s_re};
    do @(posedge clk); while (!s_tready);
    h_expected.insert(h_expected.size(), eval_h(s_re, s_im));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    wait (h_expected.size() == 0);
    @(posedge clk);
  endtask

  // leaves cfg_we high; the caller drops it after the last write
  task automatic cfg_write(reg_idx_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    if (idx <= REG_NUM_S0) num_k[REG_NUM_S0 - idx] = val;
    else den_k[REG_DEN_S0 - idx] = val;
    @(posedge clk);
  endtask

  // order: num s3..s0, den s3..s0
  task automatic load_coefs(logic [31:0] c [8]);
    drain();
    for (int i = 0; i < 8; i++) cfg_write(reg_idx_t'(i), c[i]);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(9))
      0, 1: return '0;                                   // drops the degree
      2: return $urandom();
      3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
    endcase
  endfunction

  function automatic logic [31:0] rand_point();
    case ($urandom_range(7))
      0: return $urandom();
      1: return 32'($signed($urandom_range(1 << 25)) - (1 << 24));
      default: return 32'($signed($urandom_range(1 << 18)) - (1 << 17));
    endcase
  endfunction

  // reset coefficients give H = 1 everywhere
  task automatic test_reset_defaults();
    send_point(32'h0, 32'h0);
    send_point(32'h7fffffff, 32'h80000000);
    send_point(32'h80000000, 32'h7fffffff);
    send_point(32'hffffffff, 32'h00010000);
    drain();
  endtask

  task automatic test_directed();
    logic [31:0] c [8];
    // N = s^3 + 2s + 1, D = s: zero denominator at s = 0
    c = '{32'h10000, 0, 32'h20000, 32'h10000, 0, 0, 32'h10000, 0};
    load_coefs(c);
    send_point(32'h0, 32'h0);
    send_point(32'h10000, 32'h0);
    send_point(32'h0, 32'h10000);
    send_point(32'hffff8000, 32'h00018000);
    // accumulator saturation with a huge point
    send_point(32'h7fffffff, 32'h7fffffff);
    send_point(32'h80000000, 32'h80000000);
    // all-zero denominator
    c = '{0, 0, 0, 32'h10000, 0, 0, 0, 0};
    load_coefs(c);
    send_point(32'h12345, 32'hfedcb);
    send_point(32'h0, 32'h0);
    // quotient saturation: huge numerator over a tiny denominator
    c = '{0, 0, 0, 32'h7fffffff, 0, 0, 0, 32'h1};
    load_coefs(c);
    send_point(32'h0, 32'h0);
    send_point(32'h1, 32'hffffffff);
    c = '{0, 0, 0, 32'h80000000, 0, 0, 0, 32'h1};
    load_coefs(c);
    send_point(32'h0, 32'h0);
    // coefficient extremes everywhere
    c = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
          32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff};
    load_coefs(c);
    send_point(32'h0, 32'h0);
    send_point(32'h100, 32'hffffff00);
    send_point(32'h10000, 32'h10000);
    drain();
  endtask

  // random points under changing coefficients, one idling mode
  task automatic test_random(int idle, int stall, int n_items);
    logic [31:0] c [8];
    src_idle_pct = idle;
    snk_stall_pct = stall;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) begin
        foreach (c[j]) c[j] = rand_coef();
        load_coefs(c);
      end
      send_point(rand_point(), rand_point());
    end
    drain();
  endtask

  initial begin
    num_k = '{32'sh10000, 0, 0, 0};
    den_k = '{32'sh10000, 0, 0, 0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random(0, 0, 260);
    test_random(53, 0, 260);
    test_random(0, 53, 260);
    test_random(31, 31, 260);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
